// ----- sv/assert_macros.svh -----
// Assertion macros used by the palette color indexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property violated");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- sv/pci_pkg.sv -----
// Shared constants, types and helpers of the palette color indexer.
package pci_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);
    localparam int COLOR_W      = 32;
    localparam int BPP_W        = 3;
    localparam int OUT_IDX_W    = 8;
    localparam int OUT_CNT_W    = 9;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [BPP_W-1:0] BPP_3     = 3'd3;

    // Search token passed down the cell chain.
    typedef struct packed {
        logic               act;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
    } tok_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } ctrl_state_t;

    // Keep the low bytes that make up one source pixel.
    function automatic logic [COLOR_W-1:0] color_mask(
        input logic [COLOR_W-1:0] color,
        input logic [BPP_W-1:0]   bpp
    );
        logic [COLOR_W-1:0] res;
        res = color;
        if (bpp <= 3'd2)
            res = {16'h0000, color[15:0]};
        else if (bpp == BPP_3)
            res = {8'h00, color[23:0]};
        return res;
    endfunction

endpackage

// ----- sv/palette_color_indexer_core.sv -----
// Top level of the palette color indexer: sequencer and the chain of palette cells.
// Usage:
//   Input: drive pixel_color and first_pixel with start high; the transfer
//   happens at a rising edge where start is high and busy is low. first_pixel
//   empties the palette and clears the overflow flag before the pixel is used.
//   Result: one transfer per pixel, shown for exactly one cycle with done high:
//   color_index, new_entry, overflow and palette_entries. The receiver cannot
//   stall; each result is taken at the edge that ends the done cycle.
//   Config: cfg_write loads cfg_data into bytes_per_pixel (reset 4); the
//   color is masked to 2, 3 or 4 bytes. Write only while the block is idle.
// Timing:
//   A searched pixel walks a token through all PALETTE_SIZE cells, one cell
//   per cycle; done rises after the token leaves the last cell, and the next
//   pixel can be taken in the done cycle. While the palette is in overflow
//   and the pixel is not a first pixel, done follows in the next cycle and
//   busy stays low.
// Reset:
//   Entry count, overflow flag and sequencer clear; bytes_per_pixel returns
//   to 4. Palette storage is not cleared: entries at or above the count are
//   never compared.
module palette_color_indexer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pci_pkg::COLOR_W-1:0]   pixel_color,
    input  logic                          first_pixel,
    input  logic                          cfg_write,
    input  logic [pci_pkg::BPP_W-1:0]     cfg_data,
    output logic                          done,
    output logic [pci_pkg::OUT_IDX_W-1:0] color_index,
    output logic                          new_entry,
    output logic                          overflow,
    output logic [pci_pkg::OUT_CNT_W-1:0] palette_entries
);
    import pci_pkg::*;

    // tok[i] feeds cell i; tok[PALETTE_SIZE] is the tail back to the sequencer
    tok_t             tok [0:PALETTE_SIZE];
    logic [CNT_W-1:0] count;

    pci_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_color     (pixel_color),
        .first_pixel     (first_pixel),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .tail            (tok[PALETTE_SIZE]),
        .launch          (tok[0]),
        .count           (count),
        .done            (done),
        .color_index     (color_index),
        .new_entry       (new_entry),
        .overflow        (overflow),
        .palette_entries (palette_entries)
    );

    // Cell i owns palette entry i: it matches the passing token against its
    // entry, or stores the color when it sits at the append position.
    for (genvar i = 0; i < PALETTE_SIZE; i++)
    begin : g_chain
        pci_cell u_pcell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .count    (count),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

endmodule

// ----- sv/pci_cell.sv -----
// One palette entry plus one stage of the search token chain.
module pci_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pci_pkg::IDX_W-1:0] cell_idx,
    input  logic [pci_pkg::CNT_W-1:0] count,
    input  pci_pkg::tok_t             tok_in,
    output pci_pkg::tok_t             tok_out
);
    import pci_pkg::*;

    logic [COLOR_W-1:0] entry_reg;
    logic               act_reg;
    tok_t               data_reg;
    tok_t               tok_next;
    logic               live;
    logic               hit;
    logic               wr;

    // Entries at or above the count are stale and never compared.
    assign live = tok_in.act && !tok_in.found;
    assign hit  = live && (CNT_W'(cell_idx) < count) && (entry_reg == tok_in.color);
    assign wr   = live && (CNT_W'(cell_idx) == count);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 1'b0;
        else
            act_reg <= tok_next.act;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tok_next;
        if (wr)
            entry_reg <= tok_in.color;
    end

    always_comb
    begin
        tok_out     = data_reg;
        tok_out.act = act_reg;
    end

endmodule

// ----- sv/pci_ctrl.sv -----
// Sequencer: config register, entry count, overflow flag and result registers.
`include "assert_macros.svh"
module pci_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pci_pkg::COLOR_W-1:0]   pixel_color,
    input  logic                          first_pixel,
    input  logic                          cfg_write,
    input  logic [pci_pkg::BPP_W-1:0]     cfg_data,
    input  pci_pkg::tok_t                 tail,
    output pci_pkg::tok_t                 launch,
    output logic [pci_pkg::CNT_W-1:0]     count,
    output logic                          done,
    output logic [pci_pkg::OUT_IDX_W-1:0] color_index,
    output logic                          new_entry,
    output logic                          overflow,
    output logic [pci_pkg::OUT_CNT_W-1:0] palette_entries
);
    import pci_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [BPP_W-1:0]     bpp_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 launch_act_reg, launch_act_next;
    logic [COLOR_W-1:0]   launch_color_reg, launch_color_next;
    logic                 done_reg, done_next;
    logic [OUT_IDX_W-1:0] idx_reg, idx_next;
    logic                 new_reg, new_next;
    logic                 ovf_out_reg, ovf_out_next;
    logic [OUT_CNT_W-1:0] ent_reg, ent_next;
    logic                 accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        launch_act_next   = 1'b0;
        launch_color_next = launch_color_reg;
        done_next         = 1'b0;
        idx_next          = idx_reg;
        new_next          = new_reg;
        ovf_out_next      = ovf_out_reg;
        ent_next          = ent_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (ovf_reg && !first_pixel)
                    begin
                        // palette frozen: answer at once
                        done_next    = 1'b1;
                        idx_next     = '0;
                        new_next     = 1'b0;
                        ovf_out_next = 1'b1;
                        ent_next     = OUT_CNT_W'(count_reg);
                    end
                    else
                    begin
                        if (first_pixel)
                            count_next = '0;
                        ovf_next          = 1'b0;
                        launch_act_next   = 1'b1;
                        launch_color_next = color_mask(pixel_color, bpp_reg);
                        state_next        = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tail.act)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (tail.found)
                    begin
                        idx_next     = OUT_IDX_W'(tail.idx);
                        new_next     = 1'b0;
                        ovf_out_next = 1'b0;
                        ent_next     = OUT_CNT_W'(count_reg);
                    end
                    else if (count_reg < CNT_W'(PALETTE_SIZE))
                    begin
                        // the cell at the count index stored the color
                        count_next   = count_reg + 1'b1;
                        idx_next     = OUT_IDX_W'(count_reg[IDX_W-1:0]);
                        new_next     = 1'b1;
                        ovf_out_next = 1'b0;
                        ent_next     = OUT_CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        ovf_next     = 1'b1;
                        idx_next     = '0;
                        new_next     = 1'b0;
                        ovf_out_next = 1'b1;
                        ent_next     = OUT_CNT_W'(count_reg);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bpp_reg        <= BPP_RESET;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            launch_act_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            launch_act_reg <= launch_act_next;
            done_reg       <= done_next;
            if (cfg_write)
                bpp_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        launch_color_reg <= launch_color_next;
        idx_reg          <= idx_next;
        new_reg          <= new_next;
        ovf_out_reg      <= ovf_out_next;
        ent_reg          <= ent_next;
    end

    always_comb
    begin
        launch       = '0;
        launch.act   = launch_act_reg;
        launch.color = launch_color_reg;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign count           = count_reg;
    assign done            = done_reg;
    assign color_index     = idx_reg;
    assign new_entry       = new_reg;
    assign overflow        = ovf_out_reg;
    assign palette_entries = ent_reg;

    `ASSERT_NEVER(a_tail_only_in_search, clk, rst_n, tail.act && (state_reg == ST_IDLE))
    `ASSERT_NEVER(a_new_not_ovf, clk, rst_n, done_reg && new_reg && ovf_out_reg)
    `ASSERT_HOLDS(a_new_idx_count, clk, rst_n,
        (done_reg && new_reg) |-> (ent_reg == OUT_CNT_W'(idx_reg) + 1'b1))
    `ASSERT_HOLDS(a_frozen_fast, clk, rst_n,
        (accept && ovf_reg && !first_pixel) |=> (done_reg && ovf_out_reg))
    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(PALETTE_SIZE))

endmodule

// ----- dv/tb_palette_color_indexer_core.sv -----
// Self-checking testbench for palette_color_indexer_core: directed and random pixel streams.
module tb_palette_color_indexer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pci_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    // Time allowed for one searched pixel, which moves one cell per cycle.
    localparam int ITEM_CYCLES  = PALETTE_SIZE + 2;
    localparam int LONG_GAP_MAX = 300;
    localparam int MAX_ITEMS    = 1600;
    localparam int CYCLE_LIMIT  = 3 * MAX_ITEMS * (ITEM_CYCLES + LONG_GAP_MAX + 8);

    typedef struct packed {
        logic [OUT_IDX_W-1:0] color_index;
        logic                 new_entry;
        logic                 overflow;
        logic [OUT_CNT_W-1:0] palette_entries;
    } pixel_result_t;

    // Tracks the palette as the block should build it and holds the results
    // still owed, oldest first.
    class palette_scoreboard;
        logic [COLOR_W-1:0] palette [PALETTE_SIZE];
        int unsigned        entry_count;
        bit                 overflow_seen;
        logic [BPP_W-1:0]   bytes_per_pixel;
        pixel_result_t      expected_results [$];
        int unsigned        mismatches;

        function new();
            entry_count     = 0;
            overflow_seen   = 0;
            bytes_per_pixel = BPP_RESET;
            mismatches      = 0;
        endfunction

        function void set_bytes_per_pixel(logic [BPP_W-1:0] value);
            bytes_per_pixel = value;
        endfunction

        // 0 and 1 behave as 2 bytes, 5..7 as 4 bytes.
        function logic [COLOR_W-1:0] masked_color(logic [COLOR_W-1:0] color);
            logic [COLOR_W-1:0] key;
            case (bytes_per_pixel)
                3'd0, 3'd1, 3'd2: key = {16'h0000, color[15:0]};
                3'd3:             key = {8'h00, color[23:0]};
                default:          key = color;
            endcase
            return key;
        endfunction

        function void note_pixel(logic [COLOR_W-1:0] color, logic first);
            logic [COLOR_W-1:0] key;
            pixel_result_t      res;
            bit                 found;
            key   = masked_color(color);
            res   = '0;
            found = 0;
            if (first) begin
                entry_count   = 0;
                overflow_seen = 0;
            end
            // Frozen palette after overflow: index 0, nothing added.
            if (!overflow_seen) begin
                for (int i = 0; i < entry_count; i++) begin
                    if (!found && palette[i] == key) begin
                        found           = 1;
                        res.color_index = OUT_IDX_W'(i);
                    end
                end
                if (!found) begin
                    if (entry_count >= PALETTE_SIZE) begin
                        overflow_seen = 1;
                    end else begin
                        res.color_index      = OUT_IDX_W'(entry_count);
                        palette[entry_count] = key;
                        entry_count++;
                        res.new_entry        = 1'b1;
                    end
                end
            end
            res.overflow        = overflow_seen;
            res.palette_entries = OUT_CNT_W'(entry_count);
            expected_results.push_back(res);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t want;
            if (expected_results.size() == 0) begin
                $error("result transfer with no pixel pending");
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("color_index", want.color_index, got.color_index);
            compare_field("new_entry", want.new_entry, got.new_entry);
            compare_field("overflow", want.overflow, got.overflow);
            compare_field("palette_entries", want.palette_entries, got.palette_entries);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic [COLOR_W-1:0]   pixel_color = '0;
    logic                 first_pixel = 1'b0;
    logic                 cfg_write   = 1'b0;
    logic [BPP_W-1:0]     cfg_data    = BPP_RESET;
    logic                 done;
    logic [OUT_IDX_W-1:0] color_index;
    logic                 new_entry;
    logic                 overflow;
    logic [OUT_CNT_W-1:0] palette_entries;

    palette_scoreboard palette_sb = new();
    int                sender_idle_pct;
    int                items_sent;
    int unsigned       cycle_count = 0;

    palette_color_indexer_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .pixel_color     (pixel_color),
        .first_pixel     (first_pixel),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .done            (done),
        .color_index     (color_index),
        .new_entry       (new_entry),
        .overflow        (overflow),
        .palette_entries (palette_entries)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_palette_color_indexer_core failed");
            $finish;
        end
    end

    // Sample at the rising edge. A result ending its done cycle belongs to an
    // older pixel than one taken at the same edge, so check before noting.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done)
                palette_sb.check_result(pixel_result_t'{color_index, new_entry,
                                                        overflow, palette_entries});
            if (cfg_write)
                palette_sb.set_bytes_per_pixel(cfg_data);
            if (start && !busy)
                palette_sb.note_pixel(pixel_color, first_pixel);
        end
    end

    // Present one pixel from a falling edge and hold it until the transfer.
    // Returns at the falling edge after the transfer with start still high.
    task automatic send_pixel(logic [COLOR_W-1:0] color, logic first);
        int gap;
        if ($urandom_range(99) < sender_idle_pct) begin
            // Mostly short gaps; now and then one long enough to land
            // anywhere in a full search.
            gap = ($urandom_range(7) == 0) ? $urandom_range(LONG_GAP_MAX, 1)
                                           : $urandom_range(4, 1);
            start       <= 1'b0;
            pixel_color <= $urandom;
            first_pixel <= 1'($urandom_range(1));
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        pixel_color <= color;
        first_pixel <= first;
        do @(posedge clk); while (busy);
        @(negedge clk);
        items_sent++;
    endtask

    // Every pixel gives one result, so an empty queue means the block is idle.
    task automatic wait_idle();
        start <= 1'b0;
        while (palette_sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_bpp(logic [BPP_W-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // One image: colors mostly from a small pool so hits are common, with
    // fresh colors, colors that differ only above the mask, and restarts.
    task automatic send_image(int len, int pool_size, bit fresh);
        logic [COLOR_W-1:0] pool [64];
        logic [COLOR_W-1:0] color;
        logic               first;
        int                 pick;
        for (int k = 0; k < pool_size; k++)
            pool[k] = $urandom;
        for (int n = 0; n < len; n++) begin
            pick  = $urandom_range(99);
            color = pool[$urandom_range(pool_size - 1)];
            first = (n == 0) && fresh;
            if (pick >= 97)
                first = 1'b1;
            else if (pick >= 88)
                color = $urandom;
            else if (pick >= 78)
                color[31:16] = 16'($urandom);
            send_pixel(color, first);
        end
    endtask

    // Images with a pixel size change between some of them; an unmarked
    // image continues the palette across a size change.
    task automatic run_images(int budget);
        int stop;
        stop = items_sent + budget;
        while (items_sent < stop) begin
            if ($urandom_range(3) == 0)
                write_bpp(BPP_W'($urandom_range(7)));
            send_image($urandom_range(80, 1), $urandom_range(64, 1),
                       $urandom_range(9) != 0);
        end
    endtask

    initial begin
        logic [15:0] base;
        int          back;
        sender_idle_pct = 29;
        items_sent      = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset size is 4 bytes: all 32 bits count.
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h00FF_FFFF, 1'b0);
        send_pixel(32'h8000_0000, 1'b0);
        // First pixel empties the palette.
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);

        // 3 bytes: top byte ignored.
        write_bpp(3'd3);
        send_pixel(32'h1234_5678, 1'b1);
        send_pixel(32'hAB34_5678, 1'b0);
        send_pixel(32'h0034_5679, 1'b0);

        // 2 bytes.
        write_bpp(3'd2);
        send_pixel(32'hFFFF_0000, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h0000_FFFF, 1'b0);

        // Sizes below range behave as 2 bytes.
        write_bpp(3'd0);
        send_pixel(32'h5555_AAAA, 1'b1);
        send_pixel(32'hAAAA_AAAA, 1'b0);
        write_bpp(3'd1);
        send_pixel(32'h1111_0001, 1'b0);
        send_pixel(32'hFFFF_AAAA, 1'b0);

        // Sizes above range behave as 4 bytes.
        write_bpp(3'd5);
        send_pixel(32'h1234_AAAA, 1'b0);
        write_bpp(3'd6);
        send_pixel(32'h1234_AAAA, 1'b0);
        write_bpp(3'd7);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h7FFF_FFFF, 1'b0);
        write_bpp(BPP_RESET);

        run_images(330);

        // Fill the palette with distinct 16-bit colors, random upper bits,
        // with repeats of older entries mixed in.
        sender_idle_pct = 63;
        write_bpp(3'd2);
        base = 16'($urandom);
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            send_pixel({16'($urandom), base + 16'(i * 37)}, i == 0);
            if (i > 0 && $urandom_range(99) < 30) begin
                back = $urandom_range(i);
                send_pixel({16'($urandom), base + 16'(back * 37)}, 1'b0);
            end
        end
        // Full palette still resolves hits at both ends.
        send_pixel({16'($urandom), base}, 1'b0);
        send_pixel({16'($urandom), base + 16'((PALETTE_SIZE - 1) * 37)}, 1'b0);
        // One more distinct color overflows; after that the palette is frozen
        // and each pixel is answered in the next cycle without a search.
        send_pixel({16'($urandom), base + 16'(PALETTE_SIZE * 37)}, 1'b0);
        repeat (40) send_pixel($urandom, 1'b0);
        // A first pixel clears the overflow.
        send_image(12, 4, 1'b1);

        sender_idle_pct = 0;
        run_images(380);

        wait_idle();
        // Catch any stray result after the last expected one.
        repeat (2 * ITEM_CYCLES) @(negedge clk);
        if (palette_sb.mismatches == 0 && palette_sb.pending() == 0)
            $display("tb_palette_color_indexer_core passed");
        else
            $display("tb_palette_color_indexer_core failed");
        $finish;
    end

endmodule

// ----- palette_color_indexer_core.f -----
+incdir+sv
sv/pci_pkg.sv
sv/pci_cell.sv
sv/pci_ctrl.sv
sv/palette_color_indexer_core.sv
dv/tb_palette_color_indexer_core.sv
